>>> rtl/core/prw_pkg.sv
// Shared types and constants for the Prewitt gradient magnitude block.
// No dependencies; every other file in rtl/core except prw_stream_if imports this package.
package prw_pkg;

	localparam int PIX_W      = 8;     // grey level
	localparam int ABS_W      = 10;    // |gx|, |gy| <= 765
	localparam int SQ_W       = 2 * ABS_W;
	localparam int SUM_W      = 21;    // gx^2 + gy^2 <= 1170450
	localparam int MAG_W      = 11;
	localparam int SQRT_STEPS = 11;    // one result bit per step
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 13;
	localparam int ROW_W      = 12;
	localparam int MIN_SIZE   = 3;
	localparam int MAX_HEIGHT = 4096;
	localparam int WIN_LAG    = 2;     // first input row/column with a full window
	localparam int QUEUE_DEPTH = 4;
	localparam int MAG_MAX    = 1082;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_BIT = 2;

	localparam logic IDX_IMAGE_WIDTH  = 1'b0;
	localparam logic IDX_IMAGE_HEIGHT = 1'b1;

	localparam logic [IMG_W_W-1:0] WIDTH_RESET  = IMG_W_W'(1024);
	localparam logic [IMG_H_W-1:0] HEIGHT_RESET = IMG_H_W'(1024);

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} pix_word_t;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             row_end;
		logic             frame_end;
	} mag_word_t;

	typedef struct packed {
		logic [ABS_W-1:0] abs_gx;
		logic [ABS_W-1:0] abs_gy;
		logic             row_end;
		logic             frame_end;
	} grad_word_t;

	typedef struct packed {
		logic [IMG_H_W-1:0] image_height;
		logic [IMG_W_W-1:0] image_width;
	} cfg_t;

endpackage

>>> rtl/core/prw_stream_if.sv
// Valid/ready stream channel carrying one word of any payload type.
// Used with prw_pkg word types for the pixel and magnitude channels.
interface prw_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/prw_front.sv
// Front end: raster counters, two line stores, 3x3 window and Prewitt sums.
// Pushes |gx|, |gy| and row/frame marks of interior pixels. Uses prw_pkg.
module prw_front #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  prw_pkg::cfg_t         cfg,
	prw_stream_if.sink            pix,
	output logic                  push_valid,
	input  logic                  push_ready,
	output prw_pkg::grad_word_t   push_data
);
	import prw_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ? $clog2(MAX_WIDTH + 1) : IMG_W_W;
	localparam logic [CMP_W-1:0]   WIDTH_MAX  = CMP_W'(MAX_WIDTH);
	localparam logic [CMP_W-1:0]   WIDTH_MIN  = CMP_W'(MIN_SIZE);
	localparam logic [IMG_H_W-1:0] HEIGHT_MAX = IMG_H_W'(MAX_HEIGHT);
	localparam logic [IMG_H_W-1:0] HEIGHT_MIN = IMG_H_W'(MIN_SIZE);

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [CMP_W-1:0]   width_ext;
	logic [CMP_W-1:0]   width_use;
	logic [CMP_W-1:0]   last_col_idx;
	logic [IMG_H_W-1:0] height_use;
	logic [IMG_H_W-1:0] last_row_idx;
	logic [COL_W-1:0]   col_cur;
	logic [ROW_W-1:0]   row_cur;
	logic               last_col;
	logic               last_row;
	logic               accept;

	logic               valid_s1;
	logic               res_s1;
	logic               row_end_s1;
	logic               frame_end_s1;
	logic [COL_W-1:0]   col_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [PIX_W-1:0]   top_mem_s1;
	logic [PIX_W-1:0]   mid_mem_s1;
	logic               fwd_s1;
	logic [PIX_W-1:0]   top_fwd_s1;
	logic [PIX_W-1:0]   mid_fwd_s1;
	logic               adv_s1;

	logic [PIX_W-1:0]   store_a [MAX_WIDTH];
	logic [PIX_W-1:0]   store_b [MAX_WIDTH];
	// window columns: [0..2] two back (top/mid/bot), [3..5] one back
	logic [PIX_W-1:0]   win_q [6];

	logic [PIX_W-1:0]   top_px;
	logic [PIX_W-1:0]   mid_px;
	logic [ABS_W-1:0]   sum_right;
	logic [ABS_W-1:0]   sum_left;
	logic [ABS_W-1:0]   sum_bot;
	logic [ABS_W-1:0]   sum_top;
	logic [ABS_W:0]     gx;
	logic [ABS_W:0]     gy;
	logic [ABS_W:0]     gx_abs;
	logic [ABS_W:0]     gy_abs;

	always_comb begin
		width_ext    = CMP_W'(cfg.image_width);
		if (width_ext < WIDTH_MIN) begin
			width_use = WIDTH_MIN;
		end else if (width_ext > WIDTH_MAX) begin
			width_use = WIDTH_MAX;
		end else begin
			width_use = width_ext;
		end
		last_col_idx = width_use - CMP_W'(1);

		if (cfg.image_height < HEIGHT_MIN) begin
			height_use = HEIGHT_MIN;
		end else if (cfg.image_height > HEIGHT_MAX) begin
			height_use = HEIGHT_MAX;
		end else begin
			height_use = cfg.image_height;
		end
		last_row_idx = height_use - IMG_H_W'(1);

		col_cur  = pix.data.frame_start ? '0 : col_q;
		row_cur  = pix.data.frame_start ? '0 : row_q;
		last_col = CMP_W'(col_cur) >= last_col_idx;
		last_row = IMG_H_W'(row_cur) >= last_row_idx;
	end

	assign accept    = pix.valid && pix.ready;
	assign adv_s1    = valid_s1 && (!res_s1 || push_ready);
	assign pix.ready = !valid_s1 || adv_s1;

	// line store words written by the item ahead are forwarded
	assign top_px = fwd_s1 ? top_fwd_s1 : top_mem_s1;
	assign mid_px = fwd_s1 ? mid_fwd_s1 : mid_mem_s1;

	always_comb begin
		sum_right = ABS_W'(top_px) + ABS_W'(mid_px) + ABS_W'(pix_s1);
		sum_left  = ABS_W'(win_q[0]) + ABS_W'(win_q[1]) + ABS_W'(win_q[2]);
		sum_bot   = ABS_W'(win_q[2]) + ABS_W'(win_q[5]) + ABS_W'(pix_s1);
		sum_top   = ABS_W'(win_q[0]) + ABS_W'(win_q[3]) + ABS_W'(top_px);
		gx        = {1'b0, sum_right} - {1'b0, sum_left};
		gy        = {1'b0, sum_bot} - {1'b0, sum_top};
		gx_abs    = gx[ABS_W] ? (~gx + (ABS_W+1)'(1)) : gx;
		gy_abs    = gy[ABS_W] ? (~gy + (ABS_W+1)'(1)) : gy;
	end

	assign push_valid          = valid_s1 && res_s1;
	assign push_data.abs_gx    = gx_abs[ABS_W-1:0];
	assign push_data.abs_gy    = gy_abs[ABS_W-1:0];
	assign push_data.row_end   = row_end_s1;
	assign push_data.frame_end = frame_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_cur + ROW_W'(1);
				end else begin
					col_q <= col_cur + COL_W'(1);
					row_q <= row_cur;
				end
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1       <= col_cur;
			pix_s1       <= pix.data.pixel;
			res_s1       <= (row_cur >= ROW_W'(WIN_LAG)) && (col_cur >= COL_W'(WIN_LAG));
			row_end_s1   <= last_col;
			frame_end_s1 <= last_col && last_row;
			top_mem_s1   <= store_b[col_cur];
			mid_mem_s1   <= store_a[col_cur];
			fwd_s1       <= adv_s1 && (col_s1 == col_cur);
			top_fwd_s1   <= mid_px;
			mid_fwd_s1   <= pix_s1;
		end
		if (adv_s1) begin
			store_b[col_s1] <= mid_px;
			store_a[col_s1] <= pix_s1;
			win_q[0]        <= win_q[3];
			win_q[1]        <= win_q[4];
			win_q[2]        <= win_q[5];
			win_q[3]        <= top_px;
			win_q[4]        <= mid_px;
			win_q[5]        <= pix_s1;
		end
	end

	a_frame_start_col0: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pix.data.frame_start |=> valid_s1 && col_s1 == '0 && !res_s1)
		else $error("frame start did not restart the column count");

	a_frame_end_in_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_data.frame_end |-> push_data.row_end)
		else $error("frame end without row end");

endmodule

>>> rtl/core/prw_queue.sv
// Short word queue between front end and back end (gradient words).
// Register array with head/tail pointers; uses prw_pkg.
module prw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  prw_pkg::grad_word_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output prw_pkg::grad_word_t pop_data
);
	import prw_pkg::*;

	localparam int QA_W = $clog2(QUEUE_DEPTH);

	grad_word_t      entry_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QA_W:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != (QA_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QA_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QA_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QA_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QA_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QA_W+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + (QA_W+1)'(1))
		else $error("queue count lost a word");

endmodule

>>> rtl/core/prw_back.sv
// Back end: squares, sum, and an 11-stage restoring square root pipeline.
// The whole pipeline holds while the output word is stalled. Uses prw_pkg.
module prw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  prw_pkg::grad_word_t pop_data,
	prw_stream_if.source        mag
);
	import prw_pkg::*;

	logic             enable;
	logic             valid_s1;
	logic [SQ_W-1:0]  sqx_s1;
	logic [SQ_W-1:0]  sqy_s1;
	logic             row_end_s1;
	logic             frame_end_s1;

	// index 0 holds the sum, index k+1 the state after root step k
	logic [SUM_W-1:0] rem_sk       [SQRT_STEPS+1];
	logic [SUM_W-1:0] root_sk      [SQRT_STEPS+1];
	logic             valid_sk     [SQRT_STEPS+1];
	logic             row_end_sk   [SQRT_STEPS+1];
	logic             frame_end_sk [SQRT_STEPS+1];

	assign enable    = !valid_sk[SQRT_STEPS] || mag.ready;
	assign pop_ready = enable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_sk[0] <= 1'b0;
		end else if (enable) begin
			valid_s1    <= pop_valid;
			valid_sk[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (enable) begin
			sqx_s1          <= SQ_W'(pop_data.abs_gx) * SQ_W'(pop_data.abs_gx);
			sqy_s1          <= SQ_W'(pop_data.abs_gy) * SQ_W'(pop_data.abs_gy);
			row_end_s1      <= pop_data.row_end;
			frame_end_s1    <= pop_data.frame_end;
			rem_sk[0]       <= SUM_W'(sqx_s1) + SUM_W'(sqy_s1);
			root_sk[0]      <= '0;
			row_end_sk[0]   <= row_end_s1;
			frame_end_sk[0] <= frame_end_s1;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 1 - 2 * k);
		logic [SUM_W:0] trial;
		logic           take;

		assign trial = {1'b0, root_sk[k]} + {1'b0, BIT};
		assign take  = {1'b0, rem_sk[k]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[k+1] <= 1'b0;
			end else if (enable) begin
				valid_sk[k+1] <= valid_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (enable) begin
				if (take) begin
					rem_sk[k+1]  <= rem_sk[k] - trial[SUM_W-1:0];
					root_sk[k+1] <= (root_sk[k] >> 1) + BIT;
				end else begin
					rem_sk[k+1]  <= rem_sk[k];
					root_sk[k+1] <= root_sk[k] >> 1;
				end
				row_end_sk[k+1]   <= row_end_sk[k];
				frame_end_sk[k+1] <= frame_end_sk[k];
			end
		end
	end

	assign mag.valid          = valid_sk[SQRT_STEPS];
	assign mag.data.magnitude = root_sk[SQRT_STEPS][MAG_W-1:0];
	assign mag.data.row_end   = row_end_sk[SQRT_STEPS];
	assign mag.data.frame_end = frame_end_sk[SQRT_STEPS];

	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		mag.valid |-> root_sk[SQRT_STEPS][SUM_W-1:MAG_W] == '0)
		else $error("root wider than magnitude field");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		mag.valid |-> mag.data.magnitude <= MAG_W'(MAG_MAX))
		else $error("magnitude out of range");

endmodule

>>> rtl/core/prewitt_gradient_magnitude.sv
// Prewitt 3x3 gradient magnitude, streaming: top level with register port.
// Depends on prw_pkg, prw_stream_if, prw_front, prw_queue and prw_back.
//
// Usage:
//   pix  : sink channel, one grey pixel word per handshake in raster order;
//          frame_start restarts the row and column counts on that pixel.
//   mag  : source channel, one word per interior pixel, one row and one
//          column behind the input, with row_end/frame_end marks.
//   APB  : image_width at 0x0, image_height at 0x4; write only while idle.
// Throughput is one pixel per cycle while mag is not stalled. With an empty
// path a result passes the front register (its loading edge reads the line
// stores), a queue write, the square and sum registers and 11 root steps.
// Back pressure: the whole back end holds while mag is stalled, the 4-word
// queue absorbs results meanwhile, then the front stops at its next result.
// Reset clears counters and valid bits and sets the registers to 1024 x 1024;
// line store contents are undefined until a row has been written.
module prewitt_gradient_magnitude #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [prw_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [prw_pkg::APB_DATA_W-1:0] pwdata,
	output logic [prw_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	prw_stream_if.sink                     pix,
	prw_stream_if.source                   mag
);
	import prw_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic       push_valid;
	logic       push_ready;
	grad_word_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	grad_word_t pop_data;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= WIDTH_RESET;
			cfg_q.image_height <= HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (paddr[REG_IDX_BIT])
				IDX_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[IMG_W_W-1:0];
				IDX_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[REG_IDX_BIT])
			IDX_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_q.image_width);
			IDX_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_q.image_height);
			default:          prdata = '0;
		endcase
	end

	prw_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pix        (pix),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	prw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	prw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.mag       (mag)
	);

endmodule
